### src/otsc_pkg.sv
// Shared types, constants and arithmetic helpers of the octant-table sine/cosine block.
package otsc_pkg;

    // Field formats
    localparam int ANGLE_W         = 24;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int OUT_W           = 16;
    localparam int OUT_FRAC_BITS   = 15;

    // Working precision of the reduced angle and the coefficients
    localparam int WORK_BITS = 30;
    localparam int R_W       = 32;
    localparam int ACC_W     = 64;

    // Octant estimate: angle * (4/pi), 4/pi held with K_BITS fraction bits
    localparam int K_BITS = 24;
    localparam int K_W    = 26;
    localparam int PROD_W = ANGLE_W + K_W;
    localparam int M_SH   = ANGLE_FRAC_BITS + K_BITS;
    localparam int M_W    = PROD_W - M_SH;
    localparam int MP_W   = M_W + R_W;
    localparam int OCT_W  = 3;

    // Final rounding shift from 2*WORK_BITS fraction bits down to the output
    localparam int FIN_SH = 2 * WORK_BITS - OUT_FRAC_BITS;

    // Decoupling queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    typedef logic signed [R_W-1:0]    work_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [MP_W-1:0]   mp_t;
    typedef logic signed [OUT_W-1:0]  out_t;

    // Constants, all with WORK_BITS fraction bits unless noted
    localparam logic signed [K_W-1:0] FOUR_OVER_PI = 26'sh145F306;
    localparam work_t PI_OVER_4  = 32'sh3243F6A9;
    localparam work_t COEF_A0    = 32'sh3FFDE7C0;
    localparam work_t COEF_A1    = -32'sh1F963A40;
    localparam work_t COEF_B0    = 32'sh3FFEFDC0;
    localparam work_t COEF_B1    = -32'sh0A907430;
    localparam work_t ROOT_HALF  = 32'sh2D413CC0;
    localparam acc_t  OUT_LIMIT  = 64'sd32767;
    localparam logic [OCT_W-1:0] SIN_OCT_OFS = 3'd6;

    // Reduced angle and octant handed from front to back
    typedef struct packed {
        work_t            rem;
        logic [OCT_W-1:0] oct;
    } otsc_red_t;

    // v * cos(k*pi/4); v_root is v * cos(pi/4) already formed
    function automatic acc_t rot_term(input work_t v, input acc_t v_root,
                                      input logic [OCT_W-1:0] k);
        acc_t v_one;
        acc_t res;
        v_one = acc_t'(v) <<< WORK_BITS;
        case (k)
            3'd0:    res = v_one;
            3'd1:    res = v_root;
            3'd2:    res = '0;
            3'd3:    res = -v_root;
            3'd4:    res = -v_one;
            3'd5:    res = -v_root;
            3'd6:    res = '0;
            3'd7:    res = v_root;
            default: res = '0;
        endcase
        return res;
    endfunction

    // Round half up to the output format and clamp symmetric
    function automatic out_t finish(input acc_t acc);
        acc_t v;
        out_t res;
        v = (acc + (acc_t'(1) <<< (FIN_SH - 1))) >>> FIN_SH;
        if (v > OUT_LIMIT)
            res = out_t'(OUT_LIMIT);
        else if (v < -OUT_LIMIT)
            res = out_t'(-OUT_LIMIT);
        else
            res = out_t'(v);
        return res;
    endfunction

endpackage

### src/otsc_front.sv
// Front pipeline: octant estimate and range reduction of each angle.
module otsc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [otsc_pkg::ANGLE_W-1:0] in_angle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output otsc_pkg::otsc_red_t               out_item
);
    import otsc_pkg::*;

    logic en;

    logic                        v1_reg, v1_next;
    logic signed [ANGLE_W-1:0]   a1_reg, a1_next;
    prod_t                       p1_reg, p1_next;

    logic                        v2_reg, v2_next;
    logic signed [ANGLE_W-1:0]   a2_reg, a2_next;
    logic signed [M_W-1:0]       m2_reg, m2_next;
    mp_t                         mp2_reg, mp2_next;

    logic                        v3_reg, v3_next;
    otsc_red_t                   item3_reg, item3_next;

    prod_t                       p1_rnd;
    mp_t                         diff;

    // Whole pipe moves when the last stage is empty or drains
    assign en        = !v3_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

    // Stage 1: angle times 4/pi
    always_comb
    begin
        v1_next = in_valid;
        a1_next = in_angle;
        p1_next = prod_t'(in_angle) * prod_t'(FOUR_OVER_PI);
    end

    // Stage 2: round to nearest octant, scale by pi/4
    always_comb
    begin
        p1_rnd   = p1_reg + (prod_t'(1) <<< (M_SH - 1));
        v2_next  = v1_reg;
        a2_next  = a1_reg;
        m2_next  = p1_rnd[PROD_W-1:M_SH];
        mp2_next = mp_t'(m2_next) * mp_t'(PI_OVER_4);
    end

    // Stage 3: remainder in work format
    always_comb
    begin
        diff            = (mp_t'(a2_reg) <<< (WORK_BITS - ANGLE_FRAC_BITS)) - mp2_reg;
        v3_next         = v2_reg;
        item3_next.rem  = diff[R_W-1:0];
        item3_next.oct  = m2_reg[OCT_W-1:0];
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= a1_next;
            p1_reg    <= p1_next;
            a2_reg    <= a2_next;
            m2_reg    <= m2_next;
            mp2_reg   <= mp2_next;
            item3_reg <= item3_next;
        end
    end

endmodule

### src/otsc_queue.sv
// Short queue that decouples the front and back pipelines.
module otsc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  otsc_pkg::otsc_red_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output otsc_pkg::otsc_red_t out_item
);
    import otsc_pkg::*;

    otsc_red_t        mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    // Fill never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("queue fill above depth");

    // A lone push raises the fill by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill did not follow push");

endmodule

### src/otsc_back.sv
// Back pipeline: polynomial evaluation, octant rotation, rounding and saturation.
module otsc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  otsc_pkg::otsc_red_t             in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [otsc_pkg::OUT_W-1:0] sine,
    output logic signed [otsc_pkg::OUT_W-1:0] cosine
);
    import otsc_pkg::*;

    localparam int NSTG = 7;

    logic en;
    logic [NSTG-1:0] v_reg, v_next;

    // Stage 1
    work_t            rem1_reg, rem1_next;
    work_t            r2_1_reg, r2_1_next;
    logic [OCT_W-1:0] oct1_reg, oct1_next;
    acc_t             rr;
    // Stage 2
    work_t            rem2_reg, rem2_next;
    acc_t             t1_2_reg, t1_2_next;
    acc_t             t2_2_reg, t2_2_next;
    logic [OCT_W-1:0] oct2_reg, oct2_next;
    // Stage 3
    work_t            rem3_reg, rem3_next;
    work_t            c3_reg, c3_next;
    work_t            bb3_reg, bb3_next;
    logic [OCT_W-1:0] oct3_reg, oct3_next;
    // Stage 4
    work_t            c4_reg, c4_next;
    acc_t             sp4_reg, sp4_next;
    logic [OCT_W-1:0] oct4_reg, oct4_next;
    // Stage 5
    work_t            c5_reg, c5_next;
    work_t            s5_reg, s5_next;
    acc_t             cr5_reg, cr5_next;
    acc_t             sr5_reg, sr5_next;
    logic [OCT_W-1:0] oct5_reg, oct5_next;
    // Stage 6
    acc_t             sacc6_reg, sacc6_next;
    acc_t             cacc6_reg, cacc6_next;
    // Stage 7 (output register)
    out_t             sine7_reg, sine7_next;
    out_t             cos7_reg, cos7_next;

    logic [OCT_W-1:0] sin_idx;

    // Pipe moves when the output register is empty or taken
    assign en        = !v_reg[NSTG-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[NSTG-1];
    assign sine      = sine7_reg;
    assign cosine    = cos7_reg;

    assign v_next = {v_reg[NSTG-2:0], in_valid};

    // Stage 1: r squared
    always_comb
    begin
        rr        = acc_t'(in_item.rem) * acc_t'(in_item.rem);
        rem1_next = in_item.rem;
        r2_1_next = rr[2*WORK_BITS+1:WORK_BITS];
        oct1_next = in_item.oct;
    end

    // Stage 2: coefficient products
    always_comb
    begin
        rem2_next = rem1_reg;
        t1_2_next = acc_t'(r2_1_reg) * acc_t'(COEF_A1);
        t2_2_next = acc_t'(r2_1_reg) * acc_t'(COEF_B1);
        oct2_next = oct1_reg;
    end

    // Stage 3: polynomial sums
    always_comb
    begin
        rem3_next = rem2_reg;
        c3_next   = COEF_A0 + work_t'(t1_2_reg >>> WORK_BITS);
        bb3_next  = COEF_B0 + work_t'(t2_2_reg >>> WORK_BITS);
        oct3_next = oct2_reg;
    end

    // Stage 4: odd polynomial product
    always_comb
    begin
        c4_next   = c3_reg;
        sp4_next  = acc_t'(rem3_reg) * acc_t'(bb3_reg);
        oct4_next = oct3_reg;
    end

    // Stage 5: scale both by cos(pi/4)
    always_comb
    begin
        s5_next   = work_t'(sp4_reg >>> WORK_BITS);
        c5_next   = c4_reg;
        cr5_next  = acc_t'(c4_reg) * acc_t'(ROOT_HALF);
        sr5_next  = acc_t'(s5_next) * acc_t'(ROOT_HALF);
        oct5_next = oct4_reg;
    end

    // Stage 6: rotate by the octant table
    always_comb
    begin
        sin_idx    = oct5_reg + SIN_OCT_OFS;
        sacc6_next = rot_term(c5_reg, cr5_reg, sin_idx) + rot_term(s5_reg, sr5_reg, oct5_reg);
        cacc6_next = rot_term(c5_reg, cr5_reg, oct5_reg) - rot_term(s5_reg, sr5_reg, sin_idx);
    end

    // Stage 7: round and clamp
    always_comb
    begin
        sine7_next = finish(sacc6_reg);
        cos7_next  = finish(cacc6_reg);
    end

    // Valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem1_reg  <= rem1_next;
            r2_1_reg  <= r2_1_next;
            oct1_reg  <= oct1_next;
            rem2_reg  <= rem2_next;
            t1_2_reg  <= t1_2_next;
            t2_2_reg  <= t2_2_next;
            oct2_reg  <= oct2_next;
            rem3_reg  <= rem3_next;
            c3_reg    <= c3_next;
            bb3_reg   <= bb3_next;
            oct3_reg  <= oct3_next;
            c4_reg    <= c4_next;
            sp4_reg   <= sp4_next;
            oct4_reg  <= oct4_next;
            c5_reg    <= c5_next;
            s5_reg    <= s5_next;
            cr5_reg   <= cr5_next;
            sr5_reg   <= sr5_next;
            oct5_reg  <= oct5_next;
            sacc6_reg <= sacc6_next;
            cacc6_reg <= cacc6_next;
            sine7_reg <= sine7_next;
            cos7_reg  <= cos7_next;
        end
    end

    // Clamp keeps both outputs symmetric
    a_sym_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sine != out_t'(-OUT_LIMIT - 1)) && (cosine != out_t'(-OUT_LIMIT - 1)))
        else $error("output below symmetric limit");

endmodule

### src/octant_table_sine_cosine_top.sv
// Throughput: one item per cycle unless m_tready back-pressure stalls the pipes;
// the fixed multiplier pipeline sets the rate.
// A 4-entry queue between octant reduction and polynomial back end absorbs
// output stalls, so input tready stays high until the queue fills.
// Reset (rst_n, async, active low) empties all pipeline stages and the queue.
// Top level of the octant-table sine/cosine block.
module octant_table_sine_cosine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] sine, [31:16] cosine
);
    import otsc_pkg::*;

    logic      f_valid;
    logic      f_ready;
    otsc_red_t f_item;
    logic      q_valid;
    logic      q_ready;
    otsc_red_t q_item;
    out_t      sine;
    out_t      cosine;

    otsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_angle  ($signed(s_tdata[ANGLE_W-1:0])),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    otsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    otsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sine      (sine),
        .cosine    (cosine)
    );

    // Pack result fields
    assign m_tdata = {cosine, sine};

endmodule
